>>> rtl/core/aeske_pkg.sv
// Package for the AES key expansion block.
// Holds the key length limits, the S-box table and the schedule helper functions.
// Used by the top level and its checker; depends on nothing else.
package aeske_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int BLOCK_WORDS = BLOCK_BYTES / 4;
	localparam int ROUND_EXTRA = 6;
	localparam int WIN_DEPTH = 8;
	localparam int WIN_ADDR_W = $clog2(WIN_DEPTH);
	localparam int WORD_W = 32;
	localparam int IDX_W = 6;
	localparam int KW_W = 4;

	localparam logic [KW_W-1:0] KW_MIN = 4'd4;
	localparam logic [KW_W-1:0] KW_MAX = 4'd8;
	localparam logic [KW_W-1:0] KW_RESET = 4'd4;
	localparam logic [KW_W-1:0] KW_SUB_ONLY_MIN = 4'd7;
	localparam logic [WIN_ADDR_W-1:0] SUB_ONLY_SLOT = 3'd4;
	localparam logic [7:0] RCON_INIT = 8'h01;
	localparam logic [7:0] RCON_POLY = 8'h1B;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] x);
		return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	function automatic logic [WORD_W-1:0] rot_word(input logic [WORD_W-1:0] x);
		return {x[23:0], x[31:24]};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? RCON_POLY : 8'h00);
	endfunction

	function automatic logic [KW_W-1:0] sat_key_words(input logic [KW_W-1:0] v);
		logic [KW_W-1:0] r;
		r = v;
		if (v < KW_MIN) begin
			r = KW_MIN;
		end else if (v > KW_MAX) begin
			r = KW_MAX;
		end
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] sched_len(input logic [KW_W-1:0] kw);
		return IDX_W'(BLOCK_WORDS * (int'(kw) + ROUND_EXTRA + 1));
	endfunction

endpackage

>>> rtl/core/aeske_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters; no package dependency.
module aeske_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/aes_key_expansion_top.sv
// Top level of the AES key expansion block: load sequencer, word unit and output register.
// Depends on aeske_pkg and on aeske_ram, which holds the key window.

// Key words are taken one beat per cycle and written into an eight-entry window RAM. The beat
// that completes a key of Nk words (Nk from cfg_wdata, saturated to 4..8) starts a run: input
// stalls while all 4*(Nk+7) schedule words, the key words first, stream out one per cycle while
// out_stall is low, the last one flagged. Each word is read from the window RAM through its
// registered read port before it is formed; each word past the key is written back in its
// place. Output stall holds the run where it stands.
module aes_key_expansion_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] key_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] round_key_word,
	output logic [5:0]  word_index,
	output logic        last_word
);

	typedef enum logic {ST_LOAD, ST_RUN} state_t;

	state_t state_q;
	logic [aeske_pkg::KW_W-1:0] kw_q;
	logic [aeske_pkg::KW_W-1:0] load_cnt_q;
	logic [7:0] rcon_q;
	logic [aeske_pkg::IDX_W-1:0] rd_idx_q;
	logic [aeske_pkg::WIN_ADDR_W-1:0] rd_slot_q;
	logic s1_vld_q;
	logic [aeske_pkg::IDX_W-1:0] idx_s1;
	logic [aeske_pkg::WIN_ADDR_W-1:0] slot_s1;
	logic out_vld_q;
	logic [aeske_pkg::WORD_W-1:0] out_word_q;
	logic [aeske_pkg::IDX_W-1:0] out_idx_q;
	logic out_last_q;

	logic in_acc;
	logic load_done;
	logic adv;
	logic issue;
	logic compute;
	logic is_key;
	logic is_last;
	logic [aeske_pkg::IDX_W-1:0] total;
	logic [aeske_pkg::WORD_W-1:0] rdata;
	logic [aeske_pkg::WORD_W-1:0] new_word;
	logic ram_we;
	logic [aeske_pkg::WIN_ADDR_W-1:0] ram_waddr;
	logic [aeske_pkg::WORD_W-1:0] ram_wdata;

	assign total = aeske_pkg::sched_len(kw_q);
	assign in_stall = (state_q == ST_RUN);
	assign in_acc = in_valid && !in_stall;
	assign load_done = in_acc && (4'(load_cnt_q + 4'd1) == kw_q);
	assign adv = !out_vld_q || !out_stall;
	assign compute = s1_vld_q && adv;
	assign issue = (state_q == ST_RUN) && (rd_idx_q != total) && (!s1_vld_q || adv);
	assign is_key = idx_s1 < {2'b00, kw_q};
	assign is_last = idx_s1 == 6'(total - 6'd1);

	always_comb begin
		new_word = rdata ^ out_word_q;
		if (is_key) begin
			new_word = rdata;
		end else if (slot_s1 == '0) begin
			new_word = rdata ^ aeske_pkg::sub_word(aeske_pkg::rot_word(out_word_q))
				^ {rcon_q, 24'h000000};
		end else if (kw_q >= aeske_pkg::KW_SUB_ONLY_MIN
				&& slot_s1 == aeske_pkg::SUB_ONLY_SLOT) begin
			new_word = rdata ^ aeske_pkg::sub_word(out_word_q);
		end
	end

	always_comb begin
		if (state_q == ST_LOAD) begin
			ram_we = in_acc;
			ram_waddr = load_cnt_q[aeske_pkg::WIN_ADDR_W-1:0];
			ram_wdata = key_word;
		end else begin
			ram_we = compute && !is_key;
			ram_waddr = slot_s1;
			ram_wdata = new_word;
		end
	end

	aeske_ram #(
		.WIDTH(aeske_pkg::WORD_W),
		.DEPTH(aeske_pkg::WIN_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (rd_slot_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			kw_q <= aeske_pkg::KW_RESET;
			load_cnt_q <= '0;
			rcon_q <= aeske_pkg::RCON_INIT;
			rd_idx_q <= '0;
			rd_slot_q <= '0;
			s1_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				kw_q <= aeske_pkg::sat_key_words(cfg_wdata);
				load_cnt_q <= '0;
				rcon_q <= aeske_pkg::RCON_INIT;
			end else if (load_done) begin
				load_cnt_q <= '0;
				rcon_q <= aeske_pkg::RCON_INIT;
				state_q <= ST_RUN;
				rd_idx_q <= '0;
				rd_slot_q <= '0;
			end else if (in_acc) begin
				load_cnt_q <= 4'(load_cnt_q + 4'd1);
			end

			if (issue) begin
				rd_idx_q <= 6'(rd_idx_q + 6'd1);
				if (rd_slot_q == 3'(kw_q - 4'd1)) begin
					rd_slot_q <= '0;
				end else begin
					rd_slot_q <= 3'(rd_slot_q + 3'd1);
				end
				s1_vld_q <= 1'b1;
			end else if (adv) begin
				s1_vld_q <= 1'b0;
			end

			if (compute) begin
				out_vld_q <= 1'b1;
				if (!is_key && slot_s1 == '0) begin
					rcon_q <= aeske_pkg::xtime(rcon_q);
				end
				if (is_last) begin
					state_q <= ST_LOAD;
				end
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= rd_idx_q;
			slot_s1 <= rd_slot_q;
		end
		if (compute) begin
			out_word_q <= new_word;
			out_idx_q <= idx_s1;
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_vld_q;
	assign round_key_word = out_word_q;
	assign word_index = out_idx_q;
	assign last_word = out_last_q;

endmodule

>>> rtl/core/aeske_checker.sv
// Port-level checker for the AES key expansion block, bound to the top level.
// Depends on aeske_pkg for the key length limits and the schedule length.
module aeske_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [3:0]  cfg_wdata,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] round_key_word,
	input logic [5:0]  word_index,
	input logic        last_word
);

	logic [aeske_pkg::KW_W-1:0] kw_q;
	logic [aeske_pkg::IDX_W-1:0] exp_idx_q;
	logic [aeske_pkg::IDX_W-1:0] last_idx;
	logic out_beat;

	assign out_beat = out_valid && !out_stall;
	assign last_idx = 6'(aeske_pkg::sched_len(kw_q) - 6'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_q <= aeske_pkg::KW_RESET;
			exp_idx_q <= '0;
		end else begin
			if (cfg_we) begin
				kw_q <= aeske_pkg::sat_key_words(cfg_wdata);
			end
			if (out_beat) begin
				exp_idx_q <= last_word ? '0 : 6'(word_index + 6'd1);
			end
		end
	end

	// Words of a run come out in schedule order, starting again at zero after the last.
	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_index == exp_idx_q)
		else $error("schedule word index out of order");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == last_idx)))
		else $error("last word flag does not match the schedule length");

	// No key word is taken while a run is still being produced.
	a_no_load_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_word |-> in_stall)
		else $error("input accepted during a schedule run");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(round_key_word)
			&& $stable(word_index) && $stable(last_word))
		else $error("stalled output beat changed");

endmodule

bind aes_key_expansion_top aeske_checker u_aeske_checker (.*);

>>> bench/tb_aes_key_expansion_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for aes_key_expansion_top: key words in, schedule words out.
// Predicts the key schedule with its own S-box and window; uses aeske_pkg only for the port widths.
module tb_aes_key_expansion_top;

	localparam int LEN_MIN = 4;
	localparam int LEN_MAX = 8;
	localparam int SETTLE = 20;
	localparam int DRAIN_GUARD = 200000;

	typedef struct packed {
		logic [aeske_pkg::WORD_W-1:0] word;
		logic [aeske_pkg::IDX_W-1:0]  idx;
		logic                         last;
	} sched_beat_t;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [aeske_pkg::KW_W-1:0]   cfg_wdata = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [aeske_pkg::WORD_W-1:0] key_word = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [aeske_pkg::WORD_W-1:0] round_key_word;
	logic [aeske_pkg::IDX_W-1:0]  word_index;
	logic                         last_word;

	aes_key_expansion_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.key_word       (key_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.round_key_word (round_key_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	logic [7:0]                   sbox_tab [256];
	logic [3:0]                   key_len = 4'd4;
	logic [aeske_pkg::WORD_W-1:0] key_win [8];
	logic [3:0]                   loaded = '0;
	logic [7:0]                   rcon = 8'h01;
	sched_beat_t                  expected_sched [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int mismatches = 0;
	int key_beats = 0;
	int sched_beats = 0;
	int keys_done = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [7:0] gf_double(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p ^= a;
			end
			a = gf_double(a);
		end
		return p;
	endfunction

	// Each S-box entry is the affine map of the multiplicative inverse in GF(2^8).
	function automatic void build_sbox();
		logic [7:0] inv;
		for (int v = 0; v < 256; v++) begin
			inv = (v == 0) ? 8'h00 : 8'h01;
			if (v != 0) begin
				repeat (254) inv = gf_mul(inv, 8'(v));
			end
			sbox_tab[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	endfunction

	function automatic logic [aeske_pkg::WORD_W-1:0] sub_bytes4(
		input logic [aeske_pkg::WORD_W-1:0] x);
		return {sbox_tab[x[31:24]], sbox_tab[x[23:16]], sbox_tab[x[15:8]], sbox_tab[x[7:0]]};
	endfunction

	function automatic void absorb_key_word(input logic [aeske_pkg::WORD_W-1:0] kw);
		int total;
		int slot;
		logic [aeske_pkg::WORD_W-1:0] prev;
		logic [aeske_pkg::WORD_W-1:0] t;
		logic [aeske_pkg::WORD_W-1:0] nw;
		key_win[loaded[2:0]] = kw;
		loaded = loaded + 4'd1;
		if (loaded < key_len) begin
			return;
		end
		total = 4 * (int'(key_len) + 7);
		for (int i = 0; i < key_len; i++) begin
			expected_sched.push_back('{key_win[i], (aeske_pkg::IDX_W)'(i), (i + 1 == total)});
		end
		prev = key_win[key_len - 1];
		slot = 0;
		for (int i = key_len; i < total; i++) begin
			t = prev;
			if (slot == 0) begin
				t = sub_bytes4({t[23:0], t[31:24]}) ^ {rcon, 24'h000000};
				rcon = gf_double(rcon);
			end else if (key_len > 6 && slot == 4) begin
				t = sub_bytes4(t);
			end
			nw = key_win[slot] ^ t;
			key_win[slot] = nw;
			prev = nw;
			expected_sched.push_back('{nw, (aeske_pkg::IDX_W)'(i), (i + 1 == total)});
			slot++;
			if (slot == key_len) begin
				slot = 0;
			end
		end
		loaded = '0;
		rcon = 8'h01;
		keys_done++;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (hold_req > 0) begin
			out_stall <= 1'b1;
			hold_req--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		sched_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			sched_beats++;
			if (expected_sched.size() == 0) begin
				report_mismatch("unexpected beat, word", round_key_word, '0);
			end else begin
				want = expected_sched.pop_front();
				if (round_key_word !== want.word) begin
					report_mismatch($sformatf("word %0d value", want.idx),
						round_key_word, want.word);
				end
				if (word_index !== want.idx) begin
					report_mismatch("word_index", 32'(word_index), 32'(want.idx));
				end
				if (last_word !== want.last) begin
					report_mismatch($sformatf("word %0d last_word", want.idx),
						32'(last_word), 32'(want.last));
				end
			end
		end
	end

	task automatic send_key_word(input logic [aeske_pkg::WORD_W-1:0] kw);
		int gap;
		gap = 0;
		while (gap < 60 && $urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_word <= kw;
		do @(posedge clk); while (in_stall);
		key_beats++;
		absorb_key_word(kw);
	endtask

	task automatic drain_schedule();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_sched.size() != 0 && waited < DRAIN_GUARD) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_key_len(input logic [aeske_pkg::KW_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_len = (v < LEN_MIN) ? 4'(LEN_MIN) : ((v > LEN_MAX) ? 4'(LEN_MAX) : v);
		loaded = '0;
		rcon = 8'h01;
	endtask

	function automatic logic [aeske_pkg::WORD_W-1:0] pick_key_word();
		case ($urandom_range(9))
			0: return 32'h00000000;
			1: return 32'hffffffff;
			default: return $urandom();
		endcase
	endfunction

	task automatic test_reset_length();
		send_key_word(32'h00000000);
		send_key_word(32'hffffffff);
		send_key_word(32'h00000000);
		send_key_word(32'hffffffff);
		drain_schedule();
	endtask

	task automatic test_length_saturation();
		logic [aeske_pkg::WORD_W-1:0] k128 [4] = '{32'h2b7e1516, 32'h28aed2a6,
			32'habf71588, 32'h09cf4f3c};
		logic [aeske_pkg::WORD_W-1:0] k256 [8] = '{32'h603deb10, 32'h15ca71be,
			32'h2b73aef0, 32'h857d7781, 32'h1f352c07, 32'h3b6108d7, 32'h2d9810a3,
			32'h0914dff4};
		write_key_len(4'd0);
		foreach (k128[i]) send_key_word(k128[i]);
		drain_schedule();
		write_key_len(4'd15);
		foreach (k256[i]) send_key_word(k256[i]);
		drain_schedule();
	endtask

	task automatic test_abandon_partial();
		logic [aeske_pkg::WORD_W-1:0] k192 [6] = '{32'h8e73b0f7, 32'hda0e6452,
			32'hc810f32b, 32'h809079e5, 32'h62f8ead2, 32'h522c6b7b};
		write_key_len(4'd7);
		repeat (3) send_key_word($urandom());
		drain_schedule();
		write_key_len(4'd6);
		foreach (k192[i]) send_key_word(k192[i]);
		drain_schedule();
	endtask

	// The receiver holds off while three keys are offered back to back, so the
	// block has to stall its input until the held run can drain.
	task automatic test_backpressure_fill();
		send_idle_pct = 0;
		stall_pct = 0;
		write_key_len(4'd4);
		hold_req = 400;
		repeat (12) send_key_word(pick_key_word());
		drain_schedule();
	endtask

	task automatic test_random_keys(input int n_items, input int s_idle, input int r_stall);
		int sent;
		int nkeys;
		int count;
		bit partial;
		send_idle_pct = s_idle;
		stall_pct = r_stall;
		sent = 0;
		while (sent < n_items) begin
			drain_schedule();
			write_key_len(4'($urandom_range(15)));
			nkeys = $urandom_range(1, 3);
			for (int k = 0; k < nkeys; k++) begin
				if (sent >= n_items) begin
					break;
				end
				partial = ($urandom_range(7) == 0);
				count = partial ? $urandom_range(1, key_len - 1) : int'(key_len);
				repeat (count) begin
					send_key_word(pick_key_word());
					sent++;
				end
				if (partial) begin
					break;
				end
			end
		end
		drain_schedule();
	endtask

	initial begin
		build_sbox();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_length();
		test_length_saturation();
		test_abandon_partial();
		test_backpressure_fill();
		test_random_keys(15, 0, 0);
		test_random_keys(15, 80, 0);
		test_random_keys(15, 0, 80);
		test_random_keys(15, 11, 11);
		stall_pct = 0;
		drain_schedule();
		if (expected_sched.size() != 0) begin
			report_mismatch("schedule words never delivered", 32'(expected_sched.size()), '0);
		end
		$display("Sent %0d key beats forming %0d complete keys; checked %0d schedule beats.",
			key_beats, keys_done, sched_beats);
		$display("Key lengths 4 to 8 incl. saturated writes, abandoned loads, idle and stall.");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
